// ----- rtl/gla_pkg.sv -----
// Package for greedy landmark association: widths, function codes, states.
// No dependencies.
`default_nettype none
package gla_pkg;
  localparam int unsigned MaxLandmarksDef = 32;
  localparam int unsigned CoeffFracBitsDef = 20;
  localparam int unsigned TypeBitsDef = 4;
  localparam int unsigned NumCoeffs = 12;

  typedef enum logic [1:0] {
    FUNC_LOAD_MARK  = 2'd0,
    FUNC_LOAD_COEFF = 2'd1,
    FUNC_ASSOC      = 2'd2,
    FUNC_NONE       = 2'd3
  } func_e;

  typedef enum logic {
    CFG_MAX_DIST = 1'b0,
    CFG_COUNT    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ROUND,
    ST_SCAN,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- rtl/greedy_landmark_association.sv -----
// Greedy landmark association: transform one intersection, scan landmarks.
// Depends on gla_pkg.
// Steps of an intersection: each of the 3 transform rows passes the multiply,
// sum and round states, then the scan reads each landmark in use, then a done
// state, then the result is registered.
// Loads do not set busy. One intersection at a time; busy is high meanwhile.
// The strobe result cannot be stalled. Reset clears occupancy and control registers;
// the landmark memory and coefficients are undefined until written.
`default_nettype none
module greedy_landmark_association
  import gla_pkg::*;
#(
  parameter int unsigned COEFF_FRAC_BITS = CoeffFracBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire logic [1:0]          func_i,
  input  wire logic [4:0]          slot_i,
  input  wire logic signed [15:0]  pos_x_i,
  input  wire logic signed [15:0]  pos_y_i,
  input  wire logic signed [15:0]  pos_z_i,
  input  wire logic [3:0]          kind_i,
  input  wire logic signed [23:0]  coefficient_i,
  input  wire logic                last_in_frame_i,
  output logic                     result_valid_o,
  output logic                     matched_o,
  output logic [4:0]               landmark_slot_o,
  output logic signed [15:0]       landmark_x_o,
  output logic signed [15:0]       landmark_y_o,
  output logic signed [15:0]       landmark_z_o,
  output logic signed [15:0]       field_x_o,
  output logic signed [15:0]       field_y_o,
  output logic signed [15:0]       field_z_o,
  output logic [33:0]              distance_sq_o
);
  localparam int unsigned MAX_LANDMARKS = MaxLandmarksDef;
  localparam int unsigned TYPE_BITS = TypeBitsDef;
  localparam int unsigned SlotW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_LANDMARKS + 1);
  localparam int unsigned EntW = 48 + TYPE_BITS;
  localparam int unsigned AccW = 48;

  typedef logic [EntW-1:0] entry_t;

  // landmark memory: one write, one read port, registered read
  entry_t mark_mem [MAX_LANDMARKS];
  logic signed [23:0] coeff_q [NumCoeffs];

  logic [15:0]       max_dist_q;
  logic [5:0]        count_q;
  logic [MAX_LANDMARKS-1:0] occ_q, occ_d;

  state_e            state_q, state_d;
  logic [1:0]        row_q, row_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   rd_slot_q;   // slot of data in rd_q
  logic              rd_vld_q;
  entry_t            rd_q;

  logic signed [15:0] wx_q, wy_q, wz_q;
  logic [TYPE_BITS-1:0] kind_q;
  logic               last_q;
  logic signed [AccW-1:0] p0_q, p1_q, p2_q, sum_q;
  logic signed [15:0] fx_q, fy_q, fz_q;
  logic [31:0]        limit_q;

  logic               found_q;
  logic [SlotW-1:0]   best_q;
  logic [33:0]        best_d_q;
  entry_t             best_e_q;

  logic [CntW-1:0]    n_eff;
  logic               accept;
  logic               rd_en;
  logic [SlotW-1:0]   rd_addr;

  assign accept = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign n_eff = (count_q > 6'(MAX_LANDMARKS)) ? CntW'(MAX_LANDMARKS) : CntW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= 16'd1000;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_DIST: max_dist_q <= cfg_data_i;
        CFG_COUNT:    count_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && func_e'(func_i) == FUNC_LOAD_MARK && 32'(slot_i) < MAX_LANDMARKS) begin
      mark_mem[slot_i[SlotW-1:0]] <= {kind_i[TYPE_BITS-1:0], pos_z_i, pos_y_i, pos_x_i};
    end
    if (rd_en) rd_q <= mark_mem[rd_addr];
    if (accept && func_e'(func_i) == FUNC_LOAD_COEFF && slot_i < 5'(NumCoeffs)) begin
      coeff_q[slot_i[3:0]] <= coefficient_i;
    end
  end

  assign rd_en = (state_q == ST_SCAN) && (idx_q < n_eff);
  assign rd_addr = idx_q[SlotW-1:0];

  // transform row: multiply, sum, round and saturate
  logic [3:0] c0, c1, c2, ct;
  assign c0 = 4'(row_q) * 4'd3;
  assign c1 = c0 + 4'd1;
  assign c2 = c0 + 4'd2;
  assign ct = 4'd9 + 4'(row_q);

  logic signed [AccW-1:0] q_full;
  logic signed [15:0] q_sat;
  always_comb begin
    q_full = sum_q >>> COEFF_FRAC_BITS;
    if (q_full > 48'sd32767) q_sat = 16'sh7fff;
    else if (q_full < -48'sd32768) q_sat = -16'sh8000;
    else q_sat = q_full[15:0];
  end

  // distance of the entry read last cycle
  logic signed [17:0] dx, dy, dz;
  logic signed [35:0] sx, sy, sz;
  logic [33:0] dsq;
  logic        cand;
  always_comb begin
    dx = 18'(signed'(rd_q[15:0])) - 18'(fx_q);
    dy = 18'(signed'(rd_q[31:16])) - 18'(fy_q);
    dz = 18'(signed'(rd_q[47:32])) - 18'(fz_q);
    sx = 36'(dx) * 36'(dx);
    sy = 36'(dy) * 36'(dy);
    sz = 36'(dz) * 36'(dz);
    dsq = 34'(unsigned'(sx)) + 34'(unsigned'(sy)) + 34'(unsigned'(sz));
    cand = rd_vld_q && rd_q[EntW-1:48] == kind_q
        && !occ_q[rd_slot_q[SlotW-1:0]] && dsq <= 34'(limit_q)
        && (!found_q || dsq < best_d_q);
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    idx_d = idx_q;
    occ_d = occ_q;
    busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: if (accept && func_e'(func_i) == FUNC_ASSOC) begin
        state_d = ST_MUL;
        row_d = '0;
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: state_d = ST_ROUND;
      ST_ROUND: begin
        if (row_q == 2'd2) begin
          state_d = ST_SCAN;
          idx_d = '0;
        end else begin
          row_d = row_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_SCAN: begin
        if (idx_q < n_eff) idx_d = idx_q + CntW'(1);
        else if (!rd_vld_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (found_q) occ_d[best_q] = 1'b1;
        if (last_q) occ_d = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0;
      idx_q <= '0;
      occ_q <= '0;
      rd_vld_q <= 1'b0;
      found_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      idx_q <= idx_d;
      occ_q <= occ_d;
      rd_vld_q <= rd_en;
      result_valid_o <= (state_q == ST_DONE);
      if (state_q == ST_IDLE) found_q <= 1'b0;
      else if (cand) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= idx_q;
    if (accept) begin
      wx_q <= pos_x_i;
      wy_q <= pos_y_i;
      wz_q <= pos_z_i;
      kind_q <= kind_i[TYPE_BITS-1:0];
      last_q <= last_in_frame_i;
      limit_q <= 32'(max_dist_q) * 32'(max_dist_q);
    end
    if (state_q == ST_MUL) begin
      p0_q <= AccW'(coeff_q[c0]) * AccW'(wx_q);
      p1_q <= AccW'(coeff_q[c1]) * AccW'(wy_q);
      p2_q <= AccW'(coeff_q[c2]) * AccW'(wz_q);
    end
    if (state_q == ST_SUM) begin
      sum_q <= p0_q + p1_q + p2_q + (AccW'(coeff_q[ct]) <<< COEFF_FRAC_BITS)
             + (AccW'(1) <<< (COEFF_FRAC_BITS - 1));
    end
    if (state_q == ST_ROUND) begin
      case (row_q)
        2'd0: fx_q <= q_sat;
        2'd1: fy_q <= q_sat;
        default: fz_q <= q_sat;
      endcase
    end
    if (cand) begin
      best_q <= rd_slot_q[SlotW-1:0];
      best_d_q <= dsq;
      best_e_q <= rd_q;
    end
    if (state_q == ST_DONE) begin
      matched_o <= found_q;
      landmark_slot_o <= found_q ? 5'(best_q) : '0;
      landmark_x_o <= found_q ? best_e_q[15:0] : '0;
      landmark_y_o <= found_q ? best_e_q[31:16] : '0;
      landmark_z_o <= found_q ? best_e_q[47:32] : '0;
      field_x_o <= fx_q;
      field_y_o <= fy_q;
      field_z_o <= fz_q;
      distance_sq_o <= found_q ? best_d_q : '0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/gla_checker.sv -----
// Port-level checks for greedy landmark association, bound to the top level.
// Depends on gla_pkg and greedy_landmark_association.
`default_nettype none
module gla_checker
  import gla_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  func_i,
  input wire logic        result_valid_o,
  input wire logic        matched_o,
  input wire logic [4:0]  landmark_slot_o,
  input wire logic [33:0] distance_sq_o
);
  a_assoc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i == FUNC_ASSOC |=> busy) else $error("assoc not busy");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i != FUNC_ASSOC |=> !busy) else $error("load busy");
  a_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("stray result");
  a_unmatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !matched_o |-> landmark_slot_o == '0 && distance_sq_o == '0)
    else $error("unmatched fields");
endmodule

bind greedy_landmark_association gla_checker u_gla_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .func_i(func_i),
  .result_valid_o(result_valid_o), .matched_o(matched_o),
  .landmark_slot_o(landmark_slot_o), .distance_sq_o(distance_sq_o)
);
`default_nettype wire
